// File: hdl/ocwh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ones-count word histogram: shared package
// Widths, depths, operation and command codes, and the queue entry type
// shared by the front end, the queue and the histogram back end.
// ----------------------------------------------------------------------------
package ocwh_pkg;

  // Histogram geometry.
  localparam int COUNT_WIDTH = 32;
  localparam int FOUR_DEPTH  = 625;
  localparam int FIVE_DEPTH  = 3125;
  localparam int FOUR_AW     = $clog2(FOUR_DEPTH);
  localparam int FIVE_AW     = $clog2(FIVE_DEPTH);

  // Stream bookkeeping.
  localparam logic [31:0] MAX_BYTES_RESET = 32'd256000;
  localparam logic [31:0] WARMUP_BYTES    = 32'd4;

  // Queue between front and back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = QUEUE_AW + 1;

  // Operation codes on the input channel.
  typedef logic [1:0] op_t;
  localparam op_t OP_FEED      = 2'd0;
  localparam op_t OP_READ_FOUR = 2'd1;
  localparam op_t OP_READ_FIVE = 2'd2;

  // Commands handed from the front end to the back end.
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_NONE      = 2'd0;
  localparam cmd_t CMD_BUMP      = 2'd1;
  localparam cmd_t CMD_READ_FOUR = 2'd2;
  localparam cmd_t CMD_READ_FIVE = 2'd3;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [2:0]             letter_t;

  // One classified item waiting in the queue.
  typedef struct packed {
    cmd_t               cmd;
    logic               counted;
    logic               ignored;
    logic [FOUR_AW-1:0] addr_four;
    logic [FIVE_AW-1:0] addr_five;
  } entry_t;

endpackage

// File: hdl/ocwh_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ones-count word histogram: channel interfaces
// Valid/ready channels for stream items, results and the max_bytes register.
// ----------------------------------------------------------------------------
interface ocwh_in_if;
  import ocwh_pkg::*;

  logic        valid;
  logic        ready;
  op_t         operation;
  logic [7:0]  data_byte;
  logic [11:0] count_index;

  modport source (output valid, operation, data_byte, count_index, input ready);
  modport sink   (input valid, operation, data_byte, count_index, output ready);
endinterface

interface ocwh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        counted;
  logic        ignored;

  modport source (output valid, read_data, counted, ignored, input ready);
  modport sink   (input valid, read_data, counted, ignored, output ready);
endinterface

interface ocwh_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] max_bytes;

  modport source (output valid, max_bytes, input ready);
  modport sink   (input valid, max_bytes, output ready);
endinterface

// File: hdl/ocwh_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ones-count word histogram: command queue
// Short first-in first-out queue of classified items between the front end
// and the histogram back end.
// ----------------------------------------------------------------------------
module ocwh_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ocwh_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output ocwh_pkg::entry_t pop_entry,
  output logic            not_empty
);
  import ocwh_pkg::*;

  entry_t              entries_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] count_r, count_nxt;

  assign full      = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_entry = entries_r[rd_ptr_r];

  // Pointer and fill level bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("queue read while empty");

endmodule

// File: hdl/ocwh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ones-count word histogram: front end
// Accepts stream items, keeps the byte counter and the last four letters,
// and turns each item into a histogram command with its word indices.
// ----------------------------------------------------------------------------
module ocwh_front (
  input  logic             clk,
  input  logic             rst_n,
  ocwh_in_if.sink          in_ch,
  ocwh_cfg_if.sink         cfg_ch,
  input  logic             clear_busy,
  input  logic             q_full,
  output logic             push,
  output ocwh_pkg::entry_t push_entry
);
  import ocwh_pkg::*;

  logic [31:0]  max_bytes_r;
  logic [31:0]  bytes_seen_r, bytes_seen_nxt;
  logic [11:0]  recent_r, recent_nxt;
  letter_t      letter;
  letter_t      l0, l1, l2, l3;
  logic [FOUR_AW-1:0] idx_four;
  logic [FIVE_AW-1:0] idx_five;
  logic         feed_live;

  // Letter of a byte from its number of one bits.
  function automatic letter_t letter_of(input logic [7:0] b);
    logic [3:0] ones;
    letter_t    l;
    ones = '0;
    for (int i = 0; i < 8; i++) begin
      ones = ones + 4'(b[i]);
    end
    case (ones)
      4'd0, 4'd1, 4'd2: l = 3'd0;
      4'd3:             l = 3'd1;
      4'd4:             l = 3'd2;
      4'd5:             l = 3'd3;
      default:          l = 3'd4;
    endcase
    return l;
  endfunction

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !clear_busy && !q_full;
  assign push         = in_ch.valid && in_ch.ready;

  // Word indices in base five, oldest letter most significant.
  assign letter    = letter_of(in_ch.data_byte);
  assign l0        = recent_r[11:9];
  assign l1        = recent_r[8:6];
  assign l2        = recent_r[5:3];
  assign l3        = recent_r[2:0];
  assign idx_four  = FOUR_AW'(l1) * FOUR_AW'(125) + FOUR_AW'(l2) * FOUR_AW'(25)
                   + FOUR_AW'(l3) * FOUR_AW'(5) + FOUR_AW'(letter);
  assign idx_five  = FIVE_AW'(l0) * FIVE_AW'(FOUR_DEPTH) + FIVE_AW'(idx_four);
  assign feed_live = (bytes_seen_r < max_bytes_r);

  // Classification of the item on the input channel.
  always_comb begin
    push_entry           = '0;
    push_entry.cmd       = CMD_NONE;
    bytes_seen_nxt       = bytes_seen_r;
    recent_nxt           = recent_r;
    case (in_ch.operation)
      OP_FEED: begin
        if (!feed_live) begin
          push_entry.ignored = 1'b1;
        end else if (bytes_seen_r >= WARMUP_BYTES) begin
          push_entry.cmd       = CMD_BUMP;
          push_entry.counted   = 1'b1;
          push_entry.addr_four = idx_four;
          push_entry.addr_five = idx_five;
        end
        if (push) begin
          if (feed_live) begin
            recent_nxt = {recent_r[8:0], letter};
          end
          if (bytes_seen_r != '1) begin
            bytes_seen_nxt = bytes_seen_r + 32'd1;
          end
        end
      end
      OP_READ_FOUR: begin
        if (in_ch.count_index < 12'(FOUR_DEPTH)) begin
          push_entry.cmd       = CMD_READ_FOUR;
          push_entry.addr_four = in_ch.count_index[FOUR_AW-1:0];
        end
      end
      OP_READ_FIVE: begin
        if (in_ch.count_index < 12'(FIVE_DEPTH)) begin
          push_entry.cmd       = CMD_READ_FIVE;
          push_entry.addr_five = in_ch.count_index[FIVE_AW-1:0];
        end
      end
      default: begin
        push_entry.cmd = CMD_NONE;
      end
    endcase
  end

  // Stream state and the configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r  <= MAX_BYTES_RESET;
      bytes_seen_r <= '0;
      recent_r     <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        max_bytes_r <= cfg_ch.max_bytes;
      end
      bytes_seen_r <= bytes_seen_nxt;
      recent_r     <= recent_nxt;
    end
  end

  a_bytes_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> bytes_seen_r >= $past(bytes_seen_r))
    else $error("byte counter went backwards");

endmodule

// File: hdl/ocwh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ones-count word histogram: histogram back end
// Holds both count memories, clears them after reset, and carries out bumps
// and reads as a two-stage read-modify-write pipeline with forwarding,
// followed by the output register.
// ----------------------------------------------------------------------------
module ocwh_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  ocwh_pkg::entry_t q_entry,
  output logic             q_pop,
  output logic             clear_busy,
  ocwh_out_if.source       out_ch
);
  import ocwh_pkg::*;

  // Count memories and their registered read data.
  count_t four_mem_r [FOUR_DEPTH];
  count_t five_mem_r [FIVE_DEPTH];
  count_t four_rd_r, five_rd_r;

  // Clearing pass.
  logic               clear_busy_r;
  logic [FIVE_AW-1:0] clear_cnt_r;

  // Update stage.
  logic   s2_valid_r;
  entry_t s2_entry_r;
  logic   s2_adv;
  count_t four_cur, five_cur, four_new, five_new;

  // Most recent write to each memory, for forwarding.
  logic               lw_four_valid_r, lw_five_valid_r;
  logic [FOUR_AW-1:0] lw_four_addr_r;
  logic [FIVE_AW-1:0] lw_five_addr_r;
  count_t             lw_four_data_r, lw_five_data_r;

  // Memory write ports.
  logic               four_we, five_we, bump_we;
  logic [FOUR_AW-1:0] four_wa;
  logic [FIVE_AW-1:0] five_wa;
  count_t             four_wd, five_wd;

  // Output register.
  logic        out_valid_r;
  logic [31:0] out_read_data_r, out_read_data_nxt;
  logic        out_counted_r, out_ignored_r;

  function automatic count_t sat_inc(input count_t c);
    return (c == '1) ? c : c + COUNT_WIDTH'(1);
  endfunction

  assign clear_busy = clear_busy_r;
  assign s2_adv     = s2_valid_r && (!out_valid_r || out_ch.ready);
  assign q_pop      = q_valid && !clear_busy_r && (!s2_valid_r || s2_adv);

  // Current counts with the last write forwarded over the memory read.
  always_comb begin
    four_cur = (lw_four_valid_r && lw_four_addr_r == s2_entry_r.addr_four)
             ? lw_four_data_r : four_rd_r;
    five_cur = (lw_five_valid_r && lw_five_addr_r == s2_entry_r.addr_five)
             ? lw_five_data_r : five_rd_r;
    four_new = sat_inc(four_cur);
    five_new = sat_inc(five_cur);
  end

  // Write port selection: clearing pass first, then bumps.
  always_comb begin
    bump_we = s2_adv && (s2_entry_r.cmd == CMD_BUMP);
    if (clear_busy_r) begin
      four_we = (clear_cnt_r < FIVE_AW'(FOUR_DEPTH));
      four_wa = clear_cnt_r[FOUR_AW-1:0];
      four_wd = '0;
      five_we = 1'b1;
      five_wa = clear_cnt_r;
      five_wd = '0;
    end else begin
      four_we = bump_we;
      four_wa = s2_entry_r.addr_four;
      four_wd = four_new;
      five_we = bump_we;
      five_wa = s2_entry_r.addr_five;
      five_wd = five_new;
    end
  end

  // Memories: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (four_we) begin
      four_mem_r[four_wa] <= four_wd;
    end
    if (q_pop) begin
      four_rd_r <= four_mem_r[q_entry.addr_four];
    end
  end

  always_ff @(posedge clk) begin
    if (five_we) begin
      five_mem_r[five_wa] <= five_wd;
    end
    if (q_pop) begin
      five_rd_r <= five_mem_r[q_entry.addr_five];
    end
  end

  // Clearing pass after reset, one entry of each memory a cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_busy_r <= 1'b1;
      clear_cnt_r  <= '0;
    end else if (clear_busy_r) begin
      clear_cnt_r <= clear_cnt_r + 1'b1;
      if (clear_cnt_r == FIVE_AW'(FIVE_DEPTH - 1)) begin
        clear_busy_r <= 1'b0;
      end
    end
  end

  // Forwarding registers follow every bump write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_four_valid_r <= 1'b0;
      lw_five_valid_r <= 1'b0;
    end else if (!clear_busy_r && bump_we) begin
      lw_four_valid_r <= 1'b1;
      lw_five_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!clear_busy_r && bump_we) begin
      lw_four_addr_r <= s2_entry_r.addr_four;
      lw_four_data_r <= four_new;
      lw_five_addr_r <= s2_entry_r.addr_five;
      lw_five_data_r <= five_new;
    end
  end

  // Update stage occupancy and payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (q_pop) begin
      s2_valid_r <= 1'b1;
    end else if (s2_adv) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s2_entry_r <= q_entry;
    end
  end

  // Read data for the result.
  always_comb begin
    case (s2_entry_r.cmd)
      CMD_READ_FOUR: out_read_data_nxt = 32'(four_cur);
      CMD_READ_FIVE: out_read_data_nxt = 32'(five_cur);
      default:       out_read_data_nxt = '0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_read_data_r <= out_read_data_nxt;
      out_counted_r   <= s2_entry_r.counted;
      out_ignored_r   <= s2_entry_r.ignored;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_read_data_r;
  assign out_ch.counted   = out_counted_r;
  assign out_ch.ignored   = out_ignored_r;

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy_r |-> !q_pop) else $error("item taken during clearing pass");

  a_counted_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_counted_r) |-> (out_read_data_r == '0))
    else $error("counted byte carries read data");

  a_counted_ignored_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> !(s2_entry_r.counted && s2_entry_r.ignored))
    else $error("byte both counted and ignored");

endmodule

// File: hdl/ones_count_word_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ones-count word histogram: top level
// Counts overlapping four- and five-letter words of ones-count letters over
// a byte stream and answers reads of single histogram entries.
//
//   Channel  Direction  Payload
//   in_ch    sink       operation, data_byte, count_index
//   out_ch   source     read_data, counted, ignored
//   cfg_ch   sink       max_bytes (always ready)
//
// One item per cycle is sustained while out_ch.ready is high; each item gives
// one result, which passes through the queue, the memory read and the output
// register. The rate is set by the read-modify-write loop on the count
// memories, closed by forwarding the most recent write.
// After reset both memories are cleared, one entry a cycle;
// in_ch.ready stays low during that pass.
// A stalled result waits in the output register while the queue keeps
// taking items until it holds four.
// ----------------------------------------------------------------------------
module ones_count_word_histogram (
  input  logic       clk,
  input  logic       rst_n,
  ocwh_in_if.sink    in_ch,
  ocwh_cfg_if.sink   cfg_ch,
  ocwh_out_if.source out_ch
);
  import ocwh_pkg::*;

  logic   clear_busy;
  logic   q_full;
  logic   q_push;
  logic   q_pop;
  logic   q_valid;
  entry_t push_entry;
  entry_t pop_entry;

  ocwh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .clear_busy (clear_busy),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (push_entry)
  );

  ocwh_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .not_empty  (q_valid)
  );

  ocwh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (pop_entry),
    .q_pop      (q_pop),
    .clear_busy (clear_busy),
    .out_ch     (out_ch)
  );

endmodule
